### sv/ppe_pkg.sv
package ppe_pkg;

    // operation codes of an input request
    localparam logic [1:0] OP_MEAN   = 2'd0;
    localparam logic [1:0] OP_MATRIX = 2'd1;
    localparam logic [1:0] OP_ELEM   = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_INPUT_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_OUTPUT_LENGTH = 2'd1;

    // field and datapath widths
    localparam int VALUE_W = 16;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 33;
    localparam int ACC_W   = 48;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 8;
    localparam int INLEN_W = 9;
    localparam int OUTLEN_W = 7;

    // reset values of the configuration registers
    localparam logic [INLEN_W-1:0]  INPUT_LENGTH_RST  = 9'd256;
    localparam logic [OUTLEN_W-1:0] OUTPUT_LENGTH_RST = 7'd64;

    // half an output LSB in Q.26 for round-to-nearest
    localparam logic signed [ACC_W:0] ROUND_HALF = 49'sd8192;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_WAIT,
        ST_DRAIN
    } t_state;

    // kind of token travelling down the cell chain
    typedef enum logic [1:0] {
        TK_NONE,
        TK_MWR,
        TK_ELEM
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [ROW_W-1:0]  row;
        logic              last;
    } t_tok_ctl;

    // Q.26 accumulator to Q4.12, halves toward plus infinity, saturated
    function automatic logic signed [VALUE_W-1:0] f_round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]  t;
        logic signed [ACC_W-14:0] q;
        t = $signed({acc[ACC_W-1], acc}) + ROUND_HALF;
        q = t[ACC_W:14];
        if (q > $signed(35'sd32767)) begin
            return 16'sh7fff;
        end else if (q < $signed(-35'sd32768)) begin
            return 16'sh8000;
        end else begin
            return q[VALUE_W-1:0];
        end
    endfunction

endpackage

### sv/ppe_cell.sv
module ppe_cell
    import ppe_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int MAX_IN = 256
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // token from the left neighbor
    input  t_tok_ctl                  i_ctl,
    input  logic [$clog2(MAX_IN)-1:0] i_addr,
    input  logic signed [DIFF_W-1:0]  i_data,
    // token to the right neighbor
    output t_tok_ctl                  o_ctl,
    output logic [$clog2(MAX_IN)-1:0] o_addr,
    output logic signed [DIFF_W-1:0]  o_data,
    // result shift line toward cell 0
    input  logic                      i_shift,
    input  logic signed [VALUE_W-1:0] i_res_next,
    output logic signed [VALUE_W-1:0] o_res,
    output logic                      o_done
);

    localparam int ADDR_W = $clog2(MAX_IN);

    logic [VALUE_W-1:0]         r_mem [MAX_IN];
    t_tok_ctl                   r_ctl;
    logic [ADDR_W-1:0]          r_addr;
    logic signed [DIFF_W-1:0]   r_data;
    logic signed [VALUE_W-1:0]  r_m;
    logic                       r_p_v;
    logic                       r_p_last;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [ACC_W-1:0]    r_fin;
    logic                       r_fin_v;
    logic signed [VALUE_W-1:0]  r_res;
    logic                       r_done;
    logic signed [ACC_W-1:0]    w_sum;

    // matrix row of this cell: write on a matching request, read every cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.kind == TK_MWR && 32'(i_ctl.row) == IDX) begin
            r_mem[i_addr] <= i_data[VALUE_W-1:0];
        end
        r_m <= $signed(r_mem[i_addr]);
    end

    // hand the token on to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_addr <= i_addr;
        r_data <= i_data;
    end

    // multiply the difference by the matrix entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v    <= 1'b0;
            r_p_last <= 1'b0;
        end else begin
            r_p_v    <= (r_ctl.kind == TK_ELEM);
            r_p_last <= (r_ctl.kind == TK_ELEM) && r_ctl.last;
        end
        r_prod <= r_data * r_m;
    end

    assign w_sum = r_acc + {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    // accumulate; on the last element hand over the sum and clear
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_fin_v <= 1'b0;
        end else begin
            r_fin_v <= r_p_v && r_p_last;
            if (r_p_v) begin
                r_acc <= r_p_last ? '0 : w_sum;
            end
        end
        if (r_p_v && r_p_last) begin
            r_fin <= w_sum;
        end
    end

    // round the final sum, or shift results toward the output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_fin_v;
        end
        if (r_fin_v) begin
            r_res <= f_round_sat(r_fin);
        end else if (i_shift) begin
            r_res <= i_res_next;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_addr = r_addr;
    assign o_data = r_data;
    assign o_res  = r_res;
    assign o_done = r_done;

endmodule

### sv/pca_projection_engine_core.sv
// Mean-centered projection of streamed vectors onto loaded principal components.
// Input channel (i_in_valid/o_in_ready): one request per accepted cycle. Mean and
// matrix writes load the stores; vector elements stream in order and are taken
// one per cycle, each entering a chain of MAX_OUTPUT_DIM cells, one cell per
// component row, every cell holding its matrix row and its accumulator.
// After the element that completes a vector, the input channel stops taking
// requests until the whole vector's results are delivered. The first result is
// offered once that element has passed both front stages and every cell, and the
// last cell has rounded its sum; results then leave on the output channel
// (o_out_valid/i_out_ready) one per cycle while i_out_ready is high, in row order,
// output_length of them, the final one flagged in o_last_component. The chain
// length sets the gap between the last element and the first result.
// When the receiver stalls, the current result holds and the chain waits.
// Configuration (i_cfg_valid/o_cfg_ready) is always ready: index 0 input_length,
// index 1 output_length; other indexes are dropped. Write only while idle.
// Reset (synchronous, active low) clears the accumulators, the element count and
// the control state, and sets input_length 256 and output_length 64. The mean and
// matrix stores hold nothing defined until written.
module pca_projection_engine_core
    import ppe_pkg::*;
#(
    parameter int MAX_INPUT_DIM  = 256,
    parameter int MAX_OUTPUT_DIM = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_operation,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [COL_W-1:0]          i_col,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ROW_W-1:0]          o_component_index,
    output logic signed [VALUE_W-1:0] o_component_value,
    output logic                      o_last_component,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [1:0]                i_cfg_index,
    input  logic [INLEN_W-1:0]        i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_INPUT_DIM);
    localparam int IDX_W = (MAX_OUTPUT_DIM > 1) ? $clog2(MAX_OUTPUT_DIM) : 1;

    logic [INLEN_W-1:0]        r_input_length;
    logic [OUTLEN_W-1:0]       r_output_length;
    t_state                    r_state;
    t_state                    n_state;
    logic [CNT_W-1:0]          r_cnt;
    logic [IDX_W-1:0]          r_idx;
    logic [VALUE_W-1:0]        r_mean_mem [MAX_INPUT_DIM];
    logic signed [VALUE_W-1:0] r_mean_q;
    t_tok_ctl                  r_s0_ctl;
    t_tok_ctl                  n_s0_ctl;
    logic [CNT_W-1:0]          r_s0_addr;
    logic signed [VALUE_W-1:0] r_s0_val;
    t_tok_ctl                  r_s1_ctl;
    logic [CNT_W-1:0]          r_s1_addr;
    logic signed [DIFF_W-1:0]  r_s1_data;

    logic                      w_in_acc;
    logic                      w_out_acc;
    logic [31:0]               w_in_eff;
    logic [31:0]               w_out_eff;
    logic                      w_col_ok;
    logic                      w_row_ok;
    logic                      w_elem_last;
    logic                      w_out_last;

    t_tok_ctl                  w_ctl  [MAX_OUTPUT_DIM+1];
    logic [CNT_W-1:0]          w_addr [MAX_OUTPUT_DIM+1];
    logic signed [DIFF_W-1:0]  w_data [MAX_OUTPUT_DIM+1];
    logic signed [VALUE_W-1:0] w_res  [MAX_OUTPUT_DIM+1];
    logic                      w_done [MAX_OUTPUT_DIM];

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    // clamp the lengths into their legal ranges
    always_comb begin
        if (r_input_length == '0) begin
            w_in_eff = 32'd1;
        end else if (32'(r_input_length) > MAX_INPUT_DIM) begin
            w_in_eff = 32'(MAX_INPUT_DIM);
        end else begin
            w_in_eff = 32'(r_input_length);
        end
        if (r_output_length == '0) begin
            w_out_eff = 32'd1;
        end else if (32'(r_output_length) > MAX_OUTPUT_DIM) begin
            w_out_eff = 32'(MAX_OUTPUT_DIM);
        end else begin
            w_out_eff = 32'(r_output_length);
        end
    end

    assign w_col_ok    = 32'(i_col) < MAX_INPUT_DIM;
    assign w_row_ok    = 32'(i_row) < MAX_OUTPUT_DIM;
    assign w_elem_last = (32'(r_cnt) + 32'd1) >= w_in_eff;
    assign w_out_last  = (32'(r_idx) + 32'd1) == w_out_eff;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_length  <= INPUT_LENGTH_RST;
            r_output_length <= OUTPUT_LENGTH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_INPUT_LENGTH:  r_input_length  <= i_cfg_data;
                CFG_OUTPUT_LENGTH: r_output_length <= i_cfg_data[OUTLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // mean store: write on a mean request, read at the element position
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_operation == OP_MEAN && w_col_ok) begin
            r_mean_mem[CNT_W'(i_col)] <= i_value;
        end
        if (w_in_acc && i_operation == OP_ELEM) begin
            r_mean_q <= $signed(r_mean_mem[r_cnt]);
        end
    end

    // element counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_in_acc && i_operation == OP_ELEM) begin
            r_cnt <= w_elem_last ? '0 : r_cnt + 1'b1;
        end
    end

    // decode the request into a token
    always_comb begin
        n_s0_ctl = '0;
        if (w_in_acc) begin
            case (i_operation)
                OP_MATRIX: begin
                    if (w_col_ok && w_row_ok) begin
                        n_s0_ctl.kind = TK_MWR;
                    end
                    n_s0_ctl.row = i_row;
                end
                OP_ELEM: begin
                    n_s0_ctl.kind = TK_ELEM;
                    n_s0_ctl.last = w_elem_last;
                end
                default: ;
            endcase
        end
    end

    // front stage 0: register the token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
        end else begin
            r_s0_ctl <= n_s0_ctl;
        end
        r_s0_addr <= (i_operation == OP_ELEM) ? r_cnt : CNT_W'(i_col);
        r_s0_val  <= i_value;
    end

    // front stage 1: subtract the mean from an element
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= r_s0_ctl;
        end
        r_s1_addr <= r_s0_addr;
        if (r_s0_ctl.kind == TK_ELEM) begin
            r_s1_data <= $signed({r_s0_val[VALUE_W-1], r_s0_val})
                       - $signed({r_mean_q[VALUE_W-1], r_mean_q});
        end else begin
            r_s1_data <= $signed({r_s0_val[VALUE_W-1], r_s0_val});
        end
    end

    assign w_ctl[0]  = r_s1_ctl;
    assign w_addr[0] = r_s1_addr;
    assign w_data[0] = r_s1_data;
    assign w_res[MAX_OUTPUT_DIM] = '0;

    // chain of row cells
    for (genvar k = 0; k < MAX_OUTPUT_DIM; k++) begin : g_cell
        ppe_cell #(
            .IDX    (k),
            .MAX_IN (MAX_INPUT_DIM)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[k]),
            .i_addr     (w_addr[k]),
            .i_data     (w_data[k]),
            .o_ctl      (w_ctl[k+1]),
            .o_addr     (w_addr[k+1]),
            .o_data     (w_data[k+1]),
            .i_shift    (w_out_acc),
            .i_res_next (w_res[k+1]),
            .o_res      (w_res[k]),
            .o_done     (w_done[k])
        );
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RUN: begin
                if (w_in_acc && i_operation == OP_ELEM && w_elem_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_done[MAX_OUTPUT_DIM-1]) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (w_out_acc && w_out_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    // outputs of the state machine
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_RUN:   o_in_ready  = 1'b1;
            ST_DRAIN: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // component index during the drain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_out_acc) begin
            r_idx <= w_out_last ? '0 : r_idx + 1'b1;
        end
    end

    assign o_component_index = ROW_W'(r_idx);
    assign o_component_value = w_res[0];
    assign o_last_component  = w_out_last;

    // no intake while results are pending
    a_no_intake_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input taken during drain");

    // the chain finishes only after a vector has closed
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done[MAX_OUTPUT_DIM-1] |-> (r_state == ST_WAIT))
        else $error("chain finished outside wait");

    // the final component ends the drain
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_component) |=> !o_out_valid)
        else $error("results continue after last component");

    // element count restarts when a vector closes
    a_cnt_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> (r_cnt == '0))
        else $error("element count not restarted");

    // drain starts at component zero
    a_drain_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> (r_idx == '0))
        else $error("drain does not start at row zero");

endmodule

### bench/pca_projection_engine_core_test.sv
module pca_projection_engine_core_test;
    import ppe_pkg::*;

    localparam int MAX_IN        = 256;
    localparam int MAX_OUT       = 64;
    localparam int SETTLE_CYCLES = 110;
    localparam int LONG_HOLD     = 400;
    localparam int LIMIT_CYCLES  = 1000000;

    // codes with no meaning to the block
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [1:0]                op;
        logic [ROW_W-1:0]          row;
        logic [COL_W-1:0]          col;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct {
        logic [ROW_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } comp_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_operation = OP_MEAN;
    logic [ROW_W-1:0]          i_row = '0;
    logic [COL_W-1:0]          i_col = '0;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [ROW_W-1:0]          o_component_index;
    logic signed [VALUE_W-1:0] o_component_value;
    logic                      o_last_component;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [1:0]                i_cfg_index = CFG_INPUT_LENGTH;
    logic [INLEN_W-1:0]        i_cfg_data = '0;

    // shadow copy of the block state
    logic signed [VALUE_W-1:0] mean_mem [0:MAX_IN-1];
    logic signed [VALUE_W-1:0] matrix_mem [0:MAX_OUT*MAX_IN-1];
    logic signed [ACC_W-1:0]   row_acc [0:MAX_OUT-1];
    int unsigned               elem_count;
    logic [INLEN_W-1:0]        in_len_reg;
    logic [OUTLEN_W-1:0]       out_len_reg;

    req_t        pending_reqs [$];
    comp_t       expected_components [$];
    int unsigned reqs_queued = 0;
    int unsigned reqs_taken = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    // sender and receiver pacing
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    req_t        next_req;
    comp_t       head;
    int unsigned hold_left = 0;
    logic        hold_arm = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned seg_left = 0;
    int unsigned stall_mode = 0;

    pca_projection_engine_core u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_operation       (i_operation),
        .i_row             (i_row),
        .i_col             (i_col),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_component_index (o_component_index),
        .o_component_value (o_component_value),
        .o_last_component  (o_last_component),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Q.26 accumulator to Q4.12: floor after adding half an LSB, then clamp
    function automatic logic signed [VALUE_W-1:0] round_to_q412(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0] t;
        t = (acc + 49'sd8192) >>> 14;
        if (t > 49'sd32767) begin
            return 16'sh7fff;
        end else if (t < -49'sd32768) begin
            return 16'sh8000;
        end else begin
            return t[VALUE_W-1:0];
        end
    endfunction

    // apply one accepted request to the shadow state, queue the components it emits
    task automatic project_request(input logic [1:0] op, input logic [ROW_W-1:0] row,
                                   input logic [COL_W-1:0] col,
                                   input logic signed [VALUE_W-1:0] value);
        int unsigned        pos;
        int unsigned        n_in;
        int unsigned        n_out;
        int                 r;
        logic signed [16:0] diff;
        logic signed [32:0] prod;
        comp_t              c;
        case (op)
            OP_MEAN: begin
                mean_mem[col] = value;
            end
            OP_MATRIX: begin
                matrix_mem[{row, col}] = value;
            end
            OP_ELEM: begin
                pos = (elem_count > MAX_IN - 1) ? MAX_IN - 1 : elem_count;
                diff = value - mean_mem[pos];
                for (r = 0; r < MAX_OUT; r++) begin
                    prod = diff * matrix_mem[r * MAX_IN + pos];
                    row_acc[r] = row_acc[r] + prod;
                end
                n_in = (in_len_reg == 0) ? 1 : (in_len_reg > MAX_IN) ? MAX_IN : in_len_reg;
                if (pos + 1 < n_in) begin
                    elem_count = pos + 1;
                end else begin
                    n_out = (out_len_reg == 0) ? 1 :
                            (out_len_reg > MAX_OUT) ? MAX_OUT : out_len_reg;
                    for (r = 0; r < n_out; r++) begin
                        c.index = r[ROW_W-1:0];
                        c.value = round_to_q412(row_acc[r]);
                        c.last  = (r == n_out - 1);
                        expected_components.push_back(c);
                    end
                    for (r = 0; r < MAX_OUT; r++) begin
                        row_acc[r] = '0;
                    end
                    elem_count = 0;
                end
            end
            default: begin
            end
        endcase
    endtask

    // value mix: extremes, full range, and small magnitudes that stay out of saturation
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int v;
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return $urandom_range(0, 1) ? 16'sh0000 : 16'shffff;
            3, 4: begin
                v = $urandom();
                return v[VALUE_W-1:0];
            end
            default: begin
                v = $urandom_range(0, 1023) - 512;
                return v[VALUE_W-1:0];
            end
        endcase
    endfunction

    task automatic queue_req(input logic [1:0] op, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col,
                             input logic signed [VALUE_W-1:0] value);
        req_t q;
        q.op    = op;
        q.row   = row;
        q.col   = col;
        q.value = value;
        pending_reqs.push_back(q);
        reqs_queued++;
    endtask

    task automatic queue_elem(input logic signed [VALUE_W-1:0] value);
        queue_req(OP_ELEM, ROW_W'($urandom_range(0, 63)), COL_W'($urandom_range(0, 255)),
                  value);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [INLEN_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_INPUT_LENGTH:  in_len_reg = data;
            CFG_OUTPUT_LENGTH: out_len_reg = data[OUTLEN_W-1:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_lengths(input int in_len, input int out_len);
        write_reg(CFG_INPUT_LENGTH, in_len[INLEN_W-1:0]);
        write_reg(CFG_OUTPUT_LENGTH, out_len[INLEN_W-1:0]);
    endtask

    // hold until every request is taken and every component has come, then let the chain settle
    task automatic wait_drained();
        while (reqs_taken != reqs_queued || expected_components.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // driver: bursts of requests with random gaps
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                project_request(i_operation, i_row, i_col, i_value);
                reqs_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    next_req = pending_reqs.pop_front();
                    i_in_valid  <= 1'b1;
                    i_operation <= next_req.op;
                    i_row       <= next_req.row;
                    i_col       <= next_req.col;
                    i_value     <= next_req.value;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                                  : $urandom_range(1, 12);
                        gap_left = $urandom_range(0, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: one long hold when armed, otherwise a changing stall pattern
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
            i_out_ready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                seg_left <= $urandom_range(20, 200);
            end else begin
                seg_left <= seg_left - 1;
            end
            case (stall_mode)
                0: i_out_ready <= 1'b1;
                1: i_out_ready <= 1'($urandom_range(0, 1));
                2: i_out_ready <= (cycle_count % 3 == 0);
                default: i_out_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // monitor: compare each delivered component with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_components.size() == 0) begin
                $error("component_index: expected none, got %0d", o_component_index);
                mismatches++;
            end else begin
                head = expected_components.pop_front();
                if (o_component_index !== head.index) begin
                    $error("component_index: expected %0d, got %0d",
                           head.index, o_component_index);
                    mismatches++;
                end
                if (o_component_value !== head.value) begin
                    $error("component_value: expected %0d, got %0d",
                           head.value, o_component_value);
                    mismatches++;
                end
                if (o_last_component !== head.last) begin
                    $error("last_component: expected %0d, got %0d",
                           head.last, o_last_component);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int i;
        int r;
        int k;
        int p;
        int n;
        int in_len;
        int out_len;

        for (r = 0; r < MAX_OUT; r++) begin
            row_acc[r] = '0;
        end
        elem_count  = 0;
        in_len_reg  = INPUT_LENGTH_RST;
        out_len_reg = OUTPUT_LENGTH_RST;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // one element per vector: load position zero of both stores, every row
        set_lengths(1, 64);
        queue_req(OP_MEAN, 6'h3f, 8'h00, pick_value());
        for (r = 0; r < MAX_OUT; r++) begin
            queue_req(OP_MATRIX, r[ROW_W-1:0], 8'h00, pick_value());
        end
        queue_req(OP_UNUSED, 6'h3f, 8'hff, 16'sh7fff);
        queue_req(OP_MEAN, 6'h3f, 8'hff, 16'sh8000);
        queue_req(OP_MATRIX, 6'h3f, 8'hff, 16'sh8000);
        queue_elem(16'sh8000);
        queue_elem(16'sh7fff);
        queue_elem(pick_value());
        wait_drained();

        // saturation both ways and rounding of halves
        set_lengths(1, 1);
        write_reg(CFG_SPARE_A, 9'h1ff);
        write_reg(CFG_SPARE_B, 9'h000);
        queue_req(OP_MEAN, 6'd0, 8'd0, 16'sh8000);
        queue_req(OP_MATRIX, 6'd0, 8'd0, 16'sh7fff);
        queue_elem(16'sh7fff);
        queue_elem(16'sh8000);
        queue_req(OP_MEAN, 6'd0, 8'd0, 16'sh7fff);
        queue_elem(16'sh8000);
        queue_req(OP_MATRIX, 6'd0, 8'd0, 16'sh8000);
        queue_elem(16'sh8000);
        queue_req(OP_UNUSED, 6'd0, 8'd0, 16'sh0001);
        queue_req(OP_MEAN, 6'd0, 8'd0, 16'sh0000);
        queue_req(OP_MATRIX, 6'd0, 8'd0, 16'sh0001);
        queue_elem(16'sh2000);
        queue_elem(-16'sh2000);
        queue_elem(16'sh1fff);
        queue_elem(16'shffff);
        wait_drained();

        // zero lengths act as one
        set_lengths(0, 0);
        for (i = 0; i < 2; i++) begin
            queue_elem(pick_value());
        end
        wait_drained();

        // output length above the maximum clamps to it
        set_lengths(1, 127);
        for (i = 0; i < 2; i++) begin
            queue_elem(pick_value());
        end
        wait_drained();

        // random phases; the first one runs under a long receiver hold
        for (p = 0; p < 3; p++) begin
            if (p == 0) begin
                in_len = 1;
                out_len = 40;
                n = 8;
                hold_arm <= 1'b1;
            end else begin
                in_len = $urandom_range(0, 1);
                case ($urandom_range(0, 3))
                    0: out_len = 1;
                    1: out_len = 64;
                    default: out_len = $urandom_range(2, 63);
                endcase
                n = 6;
            end
            set_lengths(in_len, out_len);
            for (i = 0; i < n; i++) begin
                k = $urandom_range(0, 99);
                if (k < 70) begin
                    queue_elem(pick_value());
                end else if (k < 82) begin
                    queue_req(OP_MEAN, ROW_W'($urandom_range(0, 63)), 8'h00, pick_value());
                end else if (k < 94) begin
                    queue_req(OP_MATRIX, ROW_W'($urandom_range(0, 63)), 8'h00,
                              pick_value());
                end else begin
                    queue_req(OP_UNUSED, ROW_W'($urandom_range(0, 63)),
                              COL_W'($urandom_range(0, 255)), pick_value());
                end
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
